// ===== rtl/core/ktd_pkg.sv =====
package ktd_pkg;

    // Default geometry of a token
    localparam int TOKEN_SIZE_DEF = 32;
    localparam int KEY_BYTES_DEF  = 8;

    // Verify byte counter: saturates at its all-ones value
    localparam int             COUNT_W   = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    // Seed and head constants
    localparam logic [63:0] SEED_MARK = 64'h5355_4E52_4953_4541;
    localparam logic [63:0] GOLD_MUL  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] HEAD_MASK = 64'h5355_4E52_4953_4544;

    // Xorshift64 shift amounts and the tap that forms a token byte
    localparam int XS_SHL_A    = 13;
    localparam int XS_SHR      = 7;
    localparam int XS_SHL_B    = 17;
    localparam int XS_BYTE_LSB = 24;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_ANSWER = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic {
        FUNC_GEN    = 1'b0,
        FUNC_VERIFY = 1'b1
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [63:0] soid;
        logic [7:0]  in_byte;
        logic        in_last;
    } t_req;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic        out_last;
        logic [63:0] found_id;
    } t_rsp;

endpackage

// ===== rtl/core/ktd_if.sv =====
interface ktd_req_if import ktd_pkg::*;;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ktd_rsp_if import ktd_pkg::*;;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ktd_mul32.sv =====
module ktd_mul32 (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    // Full 32x32 product, registered
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/ktd_xs_step.sv =====
module ktd_xs_step import ktd_pkg::*; (
    input  logic [63:0] i_word,
    output logic [63:0] o_word,
    output logic [7:0]  o_byte
);

    logic [63:0] x_a;
    logic [63:0] x_b;
    logic [63:0] x_c;

    // One 13/7/17 xorshift64 step
    always_comb begin
        x_a = i_word ^ (i_word << XS_SHL_A);
        x_b = x_a ^ (x_a >> XS_SHR);
        x_c = x_b ^ (x_b << XS_SHL_B);
    end

    assign o_word = x_c;
    assign o_byte = x_c[XS_BYTE_LSB +: 8];

endmodule

// ===== rtl/core/keyed_token_derive_and_check_unit.sv =====
// Keyed token unit. A generate transaction (func 0) takes a 64-bit id and
// returns TOKEN_SIZE token byte transactions, the last one flagged; the first
// KEY_BYTES bytes carry the id under a fixed mask, the rest come from an
// xorshift64 generator seeded from the id. An id of zero instead returns one
// reject transaction. A verify transaction (func 1) feeds one token byte; only
// the byte marked last returns a transaction, the answer, carrying the id or
// zero. Timing: the request side is ready only while the unit is idle. The
// seed needs the id times a 64-bit constant, built from three 32x32 partial
// products through one registered multiplier, so a generate first runs the
// multiply states ST_MUL_A to ST_MUL_D and then sends one byte per cycle while
// the response side takes them; a rejected id goes straight to ST_EMIT. A plain
// verify byte is taken in ST_IDLE; the final head byte starts the multiply,
// then KEY_BYTES catch-up generator steps through the same xorshift unit in
// ST_REPLAY; a last byte goes through ST_EMIT to the result register. The result
// register decouples the response handshake; a stalled response only holds
// the unit in its emitting states, ST_GEN and ST_EMIT.
module keyed_token_derive_and_check_unit import ktd_pkg::*; #(
    parameter int TOKEN_SIZE = TOKEN_SIZE_DEF,
    parameter int KEY_BYTES  = KEY_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ktd_req_if.sink      i_req,
    ktd_rsp_if.source    o_rsp
);

    localparam int STEP_W = $clog2(TOKEN_SIZE);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MUL_A  = 8'b0000_0010,
        ST_MUL_B  = 8'b0000_0100,
        ST_MUL_C  = 8'b0000_1000,
        ST_MUL_D  = 8'b0001_0000,
        ST_GEN    = 8'b0010_0000,
        ST_REPLAY = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } t_state;

    // Sequencer and verify state
    t_state               r_state, n_state;
    logic [63:0]          r_word, n_word;
    logic [63:0]          r_key, n_key;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic                 r_mism, n_mism;

    // Working registers
    logic                 r_gen, n_gen;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [63:0]          r_id, n_id;
    logic [63:0]          r_acc, n_acc;
    t_kind                r_res_kind, n_res_kind;
    logic [63:0]          r_res_id, n_res_id;

    // Result register
    logic                 r_o_valid, n_o_valid;
    t_rsp                 r_o_data, n_o_data;

    // Shared units
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    logic [63:0]          xs_word;
    logic [7:0]           xs_byte;

    logic                 out_free;
    logic [COUNT_W-1:0]   cnt_next;
    logic [63:0]          key_next;
    logic                 mism_next;
    logic [63:0]          word_next;
    logic [63:0]          cand;
    logic [63:0]          masked;
    logic [31:0]          acc_hi;

    ktd_mul32 u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    ktd_xs_step u_xs (
        .i_word (r_word),
        .o_word (xs_word),
        .o_byte (xs_byte)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_o_valid;
    assign o_rsp.data  = r_o_data;

    // Feed the multiplier with the partial product the sequencer needs next
    always_comb begin
        case (r_state)
            ST_MUL_B: begin
                mul_a = r_id[31:0];
                mul_b = GOLD_MUL[63:32];
            end
            ST_MUL_C: begin
                mul_a = r_id[63:32];
                mul_b = GOLD_MUL[31:0];
            end
            default: begin
                mul_a = r_id[31:0];
                mul_b = GOLD_MUL[31:0];
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_word     = r_word;
        n_key      = r_key;
        n_count    = r_count;
        n_mism     = r_mism;
        n_gen      = r_gen;
        n_step     = r_step;
        n_id       = r_id;
        n_acc      = r_acc;
        n_res_kind = r_res_kind;
        n_res_id   = r_res_id;
        n_o_valid  = r_o_valid;
        n_o_data   = r_o_data;

        out_free  = !r_o_valid || o_rsp.ready;
        masked    = r_id ^ HEAD_MASK;
        acc_hi    = r_acc[63:32] + mul_p[31:0];

        // Verify byte: count, gather head, or replay and compare the tail
        cnt_next  = (r_count < COUNT_MAX) ? (r_count + 1'b1) : COUNT_MAX;
        key_next  = r_key;
        mism_next = r_mism;
        word_next = r_word;
        if (r_count < COUNT_W'(KEY_BYTES)) begin
            for (int b = 0; b < 8; b++) begin
                if (r_count[2:0] == 3'(b)) begin
                    key_next[b*8 +: 8] = r_key[b*8 +: 8] | i_req.data.in_byte;
                end
            end
        end else if (r_count < COUNT_W'(TOKEN_SIZE)) begin
            word_next = xs_word;
            if (xs_byte != i_req.data.in_byte) begin
                mism_next = 1'b1;
            end
        end
        cand = key_next ^ HEAD_MASK;

        // Drop the result once taken
        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.data.func == FUNC_GEN) begin
                        // Abandon any verify in progress
                        n_key   = '0;
                        n_count = '0;
                        n_mism  = 1'b0;
                        n_word  = '0;
                        if (i_req.data.soid == 64'd0) begin
                            n_res_kind = KIND_REJECT;
                            n_res_id   = '0;
                            n_state    = ST_EMIT;
                        end else begin
                            n_id    = i_req.data.soid;
                            n_gen   = 1'b1;
                            n_state = ST_MUL_A;
                        end
                    end else if (i_req.data.in_last) begin
                        n_res_kind = KIND_ANSWER;
                        n_res_id   = (cnt_next == COUNT_W'(TOKEN_SIZE) && !mism_next
                                      && cand != 64'd0) ? cand : 64'd0;
                        n_key      = '0;
                        n_count    = '0;
                        n_mism     = 1'b0;
                        n_word     = '0;
                        n_state    = ST_EMIT;
                    end else begin
                        n_key   = key_next;
                        n_count = cnt_next;
                        n_mism  = mism_next;
                        n_word  = word_next;
                        // Head complete: derive the seed, then catch up
                        if (r_count == COUNT_W'(KEY_BYTES - 1)) begin
                            n_id    = cand;
                            n_gen   = 1'b0;
                            n_state = ST_MUL_A;
                        end
                    end
                end
            end
            ST_MUL_A: begin
                n_state = ST_MUL_B;
            end
            ST_MUL_B: begin
                n_acc   = mul_p;
                n_state = ST_MUL_C;
            end
            ST_MUL_C: begin
                n_acc[63:32] = acc_hi;
                n_state      = ST_MUL_D;
            end
            ST_MUL_D: begin
                n_word  = (SEED_MARK ^ {acc_hi, r_acc[31:0]}) | 64'd1;
                n_step  = '0;
                n_state = r_gen ? ST_GEN : ST_REPLAY;
            end
            ST_GEN: begin
                if (out_free) begin
                    n_o_valid         = 1'b1;
                    n_o_data.kind     = KIND_BYTE;
                    n_o_data.out_byte = (r_step < STEP_W'(KEY_BYTES))
                                        ? masked[{r_step[2:0], 3'b000} +: 8] : xs_byte;
                    n_o_data.out_last = (r_step == STEP_W'(TOKEN_SIZE - 1));
                    n_o_data.found_id = '0;
                    n_word            = xs_word;
                    n_step            = r_step + 1'b1;
                    if (r_step == STEP_W'(TOKEN_SIZE - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_REPLAY: begin
                n_word = xs_word;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(KEY_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_o_valid         = 1'b1;
                    n_o_data.kind     = r_res_kind;
                    n_o_data.out_byte = '0;
                    n_o_data.out_last = 1'b1;
                    n_o_data.found_id = r_res_id;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_word    <= '0;
            r_key     <= '0;
            r_count   <= '0;
            r_mism    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_word    <= n_word;
            r_key     <= n_key;
            r_count   <= n_count;
            r_mism    <= n_mism;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_gen      <= n_gen;
        r_step     <= n_step;
        r_id       <= n_id;
        r_acc      <= n_acc;
        r_res_kind <= n_res_kind;
        r_res_id   <= n_res_id;
        r_o_data   <= n_o_data;
    end

endmodule

// ===== rtl/core/ktd_checker.sv =====
module ktd_checker import ktd_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input t_req i_in_data,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_rsp i_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // An accepted generate always takes the unit out of idle and drops ready
    a_gen_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_data.func == FUNC_GEN |=> !i_in_ready)
        else $error("ready straight after a generate");

    // Answers and rejects are single, final transactions with no byte
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.kind != KIND_BYTE |->
            i_out_data.out_last && i_out_data.out_byte == 8'd0)
        else $error("answer or reject not final");

    // Token bytes and rejects carry no id
    a_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.kind != KIND_ANSWER |-> i_out_data.found_id == 64'd0)
        else $error("id on a non-answer result");

    // Reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind keyed_token_derive_and_check_unit ktd_checker u_ktd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_data   (i_req.data),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);

// ===== bench/testbench.sv =====
module testbench import ktd_pkg::*;;

    // Token geometry under test, passed to the unit as parameters
    localparam int TOK_LEN  = 32;
    localparam int HEAD_LEN = 8;

    // Values that define the token scheme
    localparam logic [63:0] SEED_XOR  = 64'h5355_4E52_4953_4541;
    localparam logic [63:0] ID_MUL    = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] HEAD_XOR  = 64'h5355_4E52_4953_4544;
    localparam int          COUNT_CAP = 127;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PRINT_CAP   = 40;

    typedef logic [7:0] t_token [TOK_LEN];

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ktd_req_if req_ch();
    ktd_rsp_if rsp_ch();

    keyed_token_derive_and_check_unit #(
        .TOKEN_SIZE (TOK_LEN),
        .KEY_BYTES  (HEAD_LEN)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #10 i_clk = ~i_clk;

    // Verify-side state of the predictor
    logic [63:0] replay_word   = '0;
    logic [63:0] head_gathered = '0;
    int          bytes_taken   = 0;
    bit          tail_differs  = 1'b0;

    // Token bytes, answers and rejects still owed by the unit, oldest first
    t_rsp outcome_q [$];

    int cycle_count = 0;
    int mismatches  = 0;
    int sent_items  = 0;

    // Idling control: steady sides never idle; a non-zero hold sets the
    // length of one receiver stall
    bit src_steady   = 1'b0;
    bit snk_steady   = 1'b0;
    int rsp_hold_len = 0;

    function automatic logic [63:0] xorshift_next(input logic [63:0] w);
        logic [63:0] x;
        x = w ^ (w << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

    function automatic logic [63:0] seed_from_id(input logic [63:0] id);
        logic [63:0] prod;
        prod = id * ID_MUL;
        return (SEED_XOR ^ prod) | 64'd1;
    endfunction

    // Full token for an id: masked id in the head, generator bytes in the tail
    function automatic void derive_token(input logic [63:0] id, output t_token tok);
        logic [63:0] w;
        logic [63:0] masked;
        w      = seed_from_id(id);
        masked = id ^ HEAD_XOR;
        for (int i = 0; i < TOK_LEN; i++) begin
            w      = xorshift_next(w);
            tok[i] = (i < HEAD_LEN) ? masked[8*i +: 8] : w[31:24];
        end
    endfunction

    function automatic void owe_result(input t_kind kind, input logic [7:0] b,
                                       input logic last, input logic [63:0] id);
        t_rsp r;
        r.kind     = kind;
        r.out_byte = b;
        r.out_last = last;
        r.found_id = id;
        outcome_q.push_back(r);
    endfunction

    function automatic void clear_verify();
        replay_word   = '0;
        head_gathered = '0;
        bytes_taken   = 0;
        tail_differs  = 1'b0;
    endfunction

    // Advance the predictor by one accepted request and queue what it owes
    function automatic void apply_request(input t_req r);
        t_token      tok;
        logic [63:0] cand;
        int          idx;
        if (r.func == FUNC_GEN) begin
            clear_verify();
            if (r.soid == '0) begin
                owe_result(KIND_REJECT, 8'd0, 1'b1, 64'd0);
            end else begin
                derive_token(r.soid, tok);
                for (int i = 0; i < TOK_LEN; i++)
                    owe_result(KIND_BYTE, tok[i], i == TOK_LEN - 1, 64'd0);
            end
        end else begin
            idx         = bytes_taken;
            bytes_taken = (idx < COUNT_CAP) ? idx + 1 : COUNT_CAP;
            if (idx < HEAD_LEN) begin
                head_gathered |= {56'd0, r.in_byte} << (8 * idx);
                // Head complete: seed the replay and skip the head positions
                if (idx + 1 == HEAD_LEN) begin
                    replay_word = seed_from_id(head_gathered ^ HEAD_XOR);
                    repeat (HEAD_LEN) replay_word = xorshift_next(replay_word);
                end
            end else if (idx < TOK_LEN) begin
                replay_word = xorshift_next(replay_word);
                if (replay_word[31:24] != r.in_byte)
                    tail_differs = 1'b1;
            end
            if (r.in_last) begin
                cand = head_gathered ^ HEAD_XOR;
                owe_result(KIND_ANSWER, 8'd0, 1'b1,
                           (bytes_taken == TOK_LEN && !tail_differs && cand != '0) ?
                           cand : 64'd0);
                clear_verify();
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    endtask

    function automatic int idle_cycles(input bit steady);
        return steady ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [63:0] pick_id();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return 64'($urandom_range(1, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Unused fields carry random content so that every input bit toggles
    function automatic t_req gen_req(input logic [63:0] id);
        t_req r;
        r.func    = FUNC_GEN;
        r.soid    = id;
        r.in_byte = 8'($urandom);
        r.in_last = 1'($urandom);
        return r;
    endfunction

    function automatic t_req verify_req(input logic [7:0] b, input logic last);
        t_req r;
        r.func    = FUNC_VERIFY;
        r.soid    = {$urandom, $urandom};
        r.in_byte = b;
        r.in_last = last;
        return r;
    endfunction

    // Offer one transaction after a random gap (none when the source is steady)
    // and hold it until accepted. Valid stays high between back-to-back transactions.
    task automatic send_item(input t_req r);
        int gap;
        gap = idle_cycles(src_steady);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        apply_request(r);
        sent_items++;
    endtask

    // Feed len verify bytes; bytes beyond the token length are random
    task automatic send_token(input t_token tok, input int len);
        for (int i = 0; i < len; i++)
            send_item(verify_req((i < TOK_LEN) ? tok[i] : 8'($urandom), i == len - 1));
    endtask

    task automatic test_generate_extremes();
        send_item(gen_req(64'd0));
        send_item(gen_req(64'd1));
        send_item(gen_req('1));
        // Masked head comes out all zero for this id
        send_item(gen_req(HEAD_XOR));
        send_item(gen_req(64'h8000_0000_0000_0000));
    endtask

    task automatic test_short_and_abandoned();
        t_token tok;
        derive_token({$urandom, $urandom}, tok);
        // Single byte marked last: wrong length
        send_item(verify_req(8'hFF, 1'b1));
        // Partial verify cut off by a generate
        send_token(tok, 3);
        send_item(gen_req({$urandom, $urandom}));
        // Head plus one tail byte marked last: wrong length after catch-up
        send_token(tok, HEAD_LEN + 1);
    endtask

    task automatic test_zero_candidate();
        t_token tok;
        derive_token(64'd0, tok);
        send_token(tok, TOK_LEN);
    endtask

    task automatic test_overlong();
        t_token tok;
        derive_token({$urandom, $urandom}, tok);
        send_token(tok, TOK_LEN + 1);
        // Long enough to drive the byte count into saturation
        send_token(tok, COUNT_CAP + 3);
    endtask

    // Generates and well-formed tokens with random ids, plus damaged ones and noise
    task automatic test_random_mix(input int count, input bit steady);
        t_token tok;
        int     stop_at;
        int     pos;
        stop_at    = sent_items + count;
        src_steady = steady;
        snk_steady = steady;
        while (sent_items < stop_at) begin
            derive_token(pick_id(), tok);
            case ($urandom_range(0, 9))
                0, 1, 2: send_item(gen_req(pick_id()));
                3, 4, 5: send_token(tok, TOK_LEN);
                6: begin
                    pos = $urandom_range(0, TOK_LEN - 1);
                    tok[pos][$urandom_range(0, 7)] ^= 1'b1;
                    send_token(tok, TOK_LEN);
                end
                7: send_token(tok, $urandom_range(1, TOK_LEN + 4));
                8: begin
                    repeat ($urandom_range(1, 6))
                        send_item(verify_req(8'($urandom), 1'($urandom)));
                end
                default: begin
                    send_token(tok, $urandom_range(1, TOK_LEN - 1));
                    send_item(gen_req(pick_id()));
                end
            endcase
        end
        src_steady = 1'b0;
        snk_steady = 1'b0;
    endtask

    // Stall the receiver for a long stretch while generates keep coming,
    // so the unit fills and drops ready on its request side
    task automatic test_back_pressure();
        src_steady   = 1'b1;
        rsp_hold_len = 400;
        repeat (4) send_item(gen_req({$urandom, $urandom}));
        src_steady   = 1'b0;
    endtask

    // Receiver: draw a stall per transaction, then take the next one
    initial begin : rsp_sink
        int stall;
        rsp_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rsp_hold_len > 0) begin
                stall        = rsp_hold_len;
                rsp_hold_len = 0;
            end else begin
                stall = idle_cycles(snk_steady);
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // Compare every accepted result transaction with the oldest one owed
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("unexpected transaction", rsp_ch.data.found_id, 64'd0);
            end else begin
                want = outcome_q.pop_front();
                if (rsp_ch.data.kind !== want.kind)
                    report_mismatch("kind", 64'(rsp_ch.data.kind), 64'(want.kind));
                if (rsp_ch.data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", 64'(rsp_ch.data.out_byte),
                                    64'(want.out_byte));
                if (rsp_ch.data.out_last !== want.out_last)
                    report_mismatch("out_last", 64'(rsp_ch.data.out_last),
                                    64'(want.out_last));
                if (rsp_ch.data.found_id !== want.found_id)
                    report_mismatch("found_id", rsp_ch.data.found_id, want.found_id);
            end
        end
    end

    // Watchdog: drop the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_generate_extremes();
        test_short_and_abandoned();
        test_zero_candidate();
        test_overlong();
        test_random_mix(80, 1'b0);
        test_back_pressure();
        test_random_mix(30, 1'b1);
        test_random_mix(50, 1'b0);

        req_ch.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
